// ----- rtl/pwmpr_pkg.sv -----
// Shared types, constants and helpers for the prime-reduced PWM modulator.
// Holds the opcode enum and constant-divisor quotient functions.
// No dependencies.
package pwmpr_pkg;

	localparam logic [7:0] DUTY_FULL = 8'd255;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	// x / 3 for 8-bit x: reciprocal multiply, exact over 0..255
	function automatic logic [7:0] div3(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd171;
		return 8'(p >> 9);
	endfunction

	// x / 5 for 8-bit x
	function automatic logic [7:0] div5(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd205;
		return 8'(p >> 10);
	endfunction

	// x / 15 for 8-bit x
	function automatic logic [7:0] div15(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd137;
		return 8'(p >> 11);
	endfunction

endpackage

// ----- rtl/pwmpr_reduce.sv -----
// Duty to reduced on/off phase lengths.
// Depends on pwmpr_pkg (DUTY_FULL, div3, div5, div15).
// On plus off is 255 = 3*5*17, so of the primes 2..13 only 3 and 5 can divide
// both lengths, and each divides the on length exactly when it divides the off length.
module pwmpr_reduce import pwmpr_pkg::*; (
	input  logic [7:0] duty,
	output logic [7:0] on_len,
	output logic [7:0] off_len
);

	logic [7:0] off_raw;
	logic [7:0] on_q3, on_q5, on_q15;
	logic [7:0] off_q3, off_q5, off_q15;
	logic       by3, by5, nonzero;

	assign off_raw = DUTY_FULL - duty;

	assign on_q3   = div3(duty);
	assign on_q5   = div5(duty);
	assign on_q15  = div15(duty);
	assign off_q3  = div3(off_raw);
	assign off_q5  = div5(off_raw);
	assign off_q15 = div15(off_raw);

	// divisibility of the duty settles it for both lengths
	assign by3     = (8'(on_q3 * 8'd3) == duty);
	assign by5     = (8'(on_q5 * 8'd5) == duty);
	assign nonzero = (duty != 8'd0) && (duty != DUTY_FULL);

	// pick the combined divisor
	always_comb begin
		priority if (!nonzero) begin
			on_len  = duty;
			off_len = off_raw;
		end else if (by3 && by5) begin
			on_len  = on_q15;
			off_len = off_q15;
		end else if (by3) begin
			on_len  = on_q3;
			off_len = off_q3;
		end else if (by5) begin
			on_len  = on_q5;
			off_len = off_q5;
		end else begin
			on_len  = duty;
			off_len = off_raw;
		end
	end

endmodule

// ----- rtl/pwm_modulator_prime_reduced.sv -----
// Top level of the prime-reduced PWM modulator.
// Depends on pwmpr_pkg and pwmpr_reduce.
//
// Each input transaction is a timer tick (op = OP_TICK) or a new duty
// (op = OP_SET), and produces exactly one result transaction carrying the pin
// level, the ticks left in the current phase and the pending-update flag.
// A new duty is reduced to small on/off lengths and waits until a tick finds the
// count at zero with the pin low. The block takes one transaction per cycle:
// an input register feeds one level of logic into the phase state and the
// output register, and the input stalls only while the output register is
// full and stalled.
module pwm_modulator_prime_reduced import pwmpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] duty,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pin_level,
	output logic [7:0] ticks_left,
	output logic       update_pending
);

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] duty_s1;

	// phase state
	logic       level_q, pending_q;
	logic [7:0] count_q, on_q, off_q, next_on_q, next_off_q;

	// next state
	logic       level_d, pending_d;
	logic [7:0] count_d, on_d, off_d, next_on_d, next_off_d;
	logic [7:0] eff_on, eff_off, red_on, red_off;
	logic       load;

	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op_t'(op);
			duty_s1 <= duty;
		end
	end

	pwmpr_reduce u_reduce (
		.duty    (duty_s1),
		.on_len  (red_on),
		.off_len (red_off)
	);

	// phase update for the transaction in stage 1
	always_comb begin
		level_d    = level_q;
		pending_d  = pending_q;
		count_d    = count_q;
		on_d       = on_q;
		off_d      = off_q;
		next_on_d  = next_on_q;
		next_off_d = next_off_q;
		load       = !level_q && pending_q;
		eff_on     = load ? next_on_q : on_q;
		eff_off    = load ? next_off_q : off_q;
		if (op_s1 == OP_SET) begin
			next_on_d  = red_on;
			next_off_d = red_off;
			pending_d  = 1'b1;
		end else if (count_q != 8'd0) begin
			count_d = count_q - 8'd1;
		end else begin
			if (load) begin
				on_d      = next_on_q;
				off_d     = next_off_q;
				pending_d = 1'b0;
			end
			// toggle, holding steady at 0% and 100%
			if (level_q) begin
				if (eff_off != 8'd0) begin
					count_d = eff_off;
					level_d = 1'b0;
				end else begin
					count_d = eff_on;
				end
			end else begin
				if (eff_on != 8'd0) begin
					count_d = eff_on;
					level_d = 1'b1;
				end else begin
					count_d = eff_off;
				end
			end
		end
	end

	// phase state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= 1'b0;
			pending_q  <= 1'b0;
			count_q    <= 8'd0;
			on_q       <= 8'd0;
			off_q      <= DUTY_FULL;
			next_on_q  <= 8'd0;
			next_off_q <= DUTY_FULL;
		end else if (advance) begin
			level_q    <= level_d;
			pending_q  <= pending_d;
			count_q    <= count_d;
			on_q       <= on_d;
			off_q      <= off_d;
			next_on_q  <= next_on_d;
			next_off_q <= next_off_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_level      <= level_d;
			ticks_left     <= count_d;
			update_pending <= pending_d;
		end
	end

	assign out_valid = out_valid_q;

	// a set always leaves an update pending
	a_set_pends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_SET |=> pending_q)
		else $error("pending not set after duty transaction");

	// a tick with a running count only decrements it
	a_tick_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TICK && count_q != 8'd0
		|=> count_q == $past(count_q) - 8'd1 && level_q == $past(level_q))
		else $error("running count not decremented");

	// new lengths load only while the pin is low
	a_load_low: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pending_q) |-> !$past(level_q))
		else $error("pending lengths loaded while pin high");

	// a full output register with stall holds its result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(ticks_left)
		&& $stable(pin_level) && $stable(update_pending))
		else $error("stalled result changed");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the prime-reduced PWM modulator. Depends on pwmpr_pkg.
// Drives tick and set-duty transactions with random gaps and output stalls and checks
// each result against a cycle-free model of the phase state or a hand-written result.
module tb_top;
	import pwmpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS  = 700;
	localparam int FULL_HOLD   = 300;
	localparam int N_DIR       = 19;

	typedef struct packed {
		logic       level;
		logic [7:0] ticks;
		logic       pend;
	} pwm_res_t;

	typedef struct {
		op_t        kind;
		logic [7:0] val;
		bit         fixed;
		pwm_res_t   res;
	} stim_row_t;

	// Directed stimulus; rows marked fixed carry a hand-written result
	stim_row_t dir_tab [N_DIR] = '{
		'{OP_SET,  8'd255, 1'b1, '{1'b0, 8'd0, 1'b1}},	// fully on, not yet loaded
		'{OP_SET,  8'd0,   1'b1, '{1'b0, 8'd0, 1'b1}},	// later set replaces it
		'{OP_SET,  8'd15,  1'b1, '{1'b0, 8'd0, 1'b1}},	// reduces to 1/16
		'{OP_TICK, 8'hAA,  1'b1, '{1'b1, 8'd1, 1'b0}},	// load while low, go high
		'{OP_TICK, 8'h55,  1'b1, '{1'b1, 8'd0, 1'b0}},
		'{OP_SET,  8'd240, 1'b1, '{1'b1, 8'd0, 1'b1}},	// reduces to 16/1
		'{OP_TICK, 8'h00,  1'b0, '0},			// zero count while high: no load
		'{OP_SET,  8'd1,   1'b0, '0},
		'{OP_SET,  8'd254, 1'b0, '0},
		'{OP_SET,  8'd128, 1'b0, '0},
		'{OP_TICK, 8'hFF,  1'b0, '0},
		'{OP_SET,  8'd85,  1'b0, '0},
		'{OP_SET,  8'd170, 1'b0, '0},
		'{OP_SET,  8'd105, 1'b0, '0},
		'{OP_TICK, 8'h00,  1'b0, '0},
		'{OP_SET,  8'd127, 1'b0, '0},
		'{OP_SET,  8'd120, 1'b0, '0},
		'{OP_TICK, 8'h80,  1'b0, '0},
		'{OP_TICK, 8'h7F,  1'b0, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	op_t        op;
	logic [7:0] duty;
	logic       out_valid;
	logic       out_stall;
	logic       pin_level;
	logic [7:0] ticks_left;
	logic       update_pending;

	pwm_modulator_prime_reduced dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.duty          (duty),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pin_level     (pin_level),
		.ticks_left    (ticks_left),
		.update_pending(update_pending)
	);

	// Model state of the modulator
	logic       m_level;
	logic [7:0] m_count;
	logic [7:0] m_on;
	logic [7:0] m_off;
	logic       m_pend;
	logic [7:0] m_next_on;
	logic [7:0] m_next_off;

	pwm_res_t expected_q [$];
	int       errors;
	int       cycles;
	bit       quiet_tx;
	bit       quiet_rx;
	int       n_sent;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Divide on/off by each small prime that divides both, once each
	function automatic logic [15:0] ratio_reduce(input logic [7:0] on_len,
			input logic [7:0] off_len);
		int primes [6] = '{2, 3, 5, 7, 11, 13};
		int a;
		int b;
		a = on_len;
		b = off_len;
		foreach (primes[i]) begin
			if (primes[i] > a || primes[i] > b)
				break;
			if (a % primes[i] == 0 && b % primes[i] == 0) begin
				a = a / primes[i];
				b = b / primes[i];
			end
		end
		return {a[7:0], b[7:0]};
	endfunction

	// Advance the model by one transaction and return its result
	function automatic pwm_res_t pwm_advance(input op_t kind, input logic [7:0] val);
		logic [15:0] lens;
		pwm_res_t    r;
		if (kind == OP_SET) begin
			lens = {val, DUTY_FULL - val};
			if (val != 8'd0 && val != DUTY_FULL)
				lens = ratio_reduce(val, DUTY_FULL - val);
			m_next_on  = lens[15:8];
			m_next_off = lens[7:0];
			m_pend     = 1'b1;
		end else if (m_count != 8'd0) begin
			m_count = m_count - 8'd1;
		end else begin
			if (!m_level && m_pend) begin
				m_on   = m_next_on;
				m_off  = m_next_off;
				m_pend = 1'b0;
			end
			if (m_level) begin
				if (m_off != 8'd0) begin
					m_count = m_off;
					m_level = 1'b0;
				end else begin
					m_count = m_on;
				end
			end else begin
				if (m_on != 8'd0) begin
					m_count = m_on;
					m_level = 1'b1;
				end else begin
					m_count = m_off;
				end
			end
		end
		r.level = m_level;
		r.ticks = m_count;
		r.pend  = m_pend;
		return r;
	endfunction

	// Mostly short, a few long; none during quiet stretches
	function automatic int pick_len(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic drive_item(input op_t kind, input logic [7:0] val, input bit fixed,
			input pwm_res_t fixed_res);
		pwm_res_t r;
		logic     stalled;
		int       gap;
		in_valid <= 1'b1;
		op       <= kind;
		duty     <= val;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled !== 1'b0);
		r = pwm_advance(kind, val);
		if (fixed)
			r = fixed_res;
		expected_q.push_back(r);
		n_sent++;
		if (n_sent % 64 == 0)
			quiet_tx = ($urandom_range(0, 3) == 0);
		gap = pick_len(quiet_tx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send(input op_t kind, input logic [7:0] val);
		drive_item(kind, val, 1'b0, '0);
	endtask

	// Result monitor and output stall generator
	initial begin
		logic     ov;
		logic     os;
		pwm_res_t got;
		pwm_res_t want;
		int       stall_run;
		int       rx_cyc;
		stall_run = 0;
		rx_cyc    = 0;
		forever begin
			@(negedge clk);
			ov  = out_valid;
			os  = out_stall;
			got = {pin_level, ticks_left, update_pending};
			@(posedge clk);
			if (ov === 1'b1 && os === 1'b0) begin
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected result level=%0b ticks=%0d pend=%0b",
						got.level, got.ticks, got.pend));
				end else begin
					want = expected_q.pop_front();
					if (got.level !== want.level)
						report($sformatf("pin_level %b, want %b", got.level, want.level));
					if (got.ticks !== want.ticks)
						report($sformatf("ticks_left %0d, want %0d", got.ticks, want.ticks));
					if (got.pend !== want.pend)
						report($sformatf("update_pending %b, want %b", got.pend, want.pend));
				end
			end
			rx_cyc++;
			if (rx_cyc % 100 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			if (stall_run > 0) begin
				out_stall <= 1'b1;
				stall_run--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 99) < 25)
					stall_run = pick_len(quiet_rx);
			end
		end
	end

	// Stimulus
	initial begin
		int         k;
		logic [7:0] d;
		errors     = 0;
		cycles     = 0;
		n_sent     = 0;
		quiet_tx   = 1'b0;
		quiet_rx   = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = OP_TICK;
		duty       = 8'd0;
		out_stall  = 1'b0;
		m_level    = 1'b0;
		m_count    = 8'd0;
		m_on       = 8'd0;
		m_off      = DUTY_FULL;
		m_pend     = 1'b0;
		m_next_on  = 8'd0;
		m_next_off = DUTY_FULL;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			drive_item(dir_tab[i].kind, dir_tab[i].val, dir_tab[i].fixed, dir_tab[i].res);

		// Random traffic; a loaded 100% duty would lock the pin high, so it only
		// ever appears replaced by a following set before any tick
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 80) begin
				send(OP_TICK, 8'($urandom_range(0, 255)));
			end else begin
				k = $urandom_range(0, 9);
				if (k < 6)
					d = 8'(15 * $urandom_range(0, 16));
				else
					d = 8'($urandom_range(0, 254));
				if (k == 9)
					send(OP_SET, DUTY_FULL);
				send(OP_SET, d);
			end
		end

		// Fully on: load it, then watch the high phase reload
		send(OP_SET, DUTY_FULL);
		while (!(m_level && !m_pend && m_off == 8'd0))
			send(OP_TICK, 8'($urandom_range(0, 255)));
		repeat (FULL_HOLD)
			send(OP_TICK, 8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pwmpr_pkg.sv
rtl/pwmpr_reduce.sv
rtl/pwm_modulator_prime_reduced.sv
tb/tb_top.sv
